### sv/eif_pkg.sv
// Shared types, constants and codes for the egress IP filter.
package eif_pkg;

  // Allowlist size and the widths that follow from it.
  localparam int LIST_ENTRIES = 16;
  localparam int IDX_W = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
  localparam int CNT_W = $clog2(LIST_ENTRIES + 1);

  // Depth of the queue between the classifier and the list engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One allowlist entry as stored in the RAM: family, high half, low half.
  localparam int ENTRY_W = 129;

  // Operation codes.
  localparam logic [1:0] OP_CHECK  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Scope classes.
  localparam logic [2:0] CLS_PUBLIC      = 3'd0;
  localparam logic [2:0] CLS_LOOPBACK    = 3'd1;
  localparam logic [2:0] CLS_LINKLOCAL   = 3'd2;
  localparam logic [2:0] CLS_PRIVATE     = 3'd3;
  localparam logic [2:0] CLS_MULTICAST   = 3'd4;
  localparam logic [2:0] CLS_UNSPECIFIED = 3'd5;
  localparam logic [2:0] CLS_RESERVED    = 3'd6;

  // A classified request waiting for the list engine.
  typedef struct packed {
    logic [1:0]  opcode;
    logic        is_ipv6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [2:0]  ip_class;
  } item_t;

endpackage

### sv/eif_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module eif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/eif_front.sv
// Front end: accepts requests, classifies the address and queues the result.
module eif_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [127:0]        s_tdata,
  input  logic [2:0]          s_tuser,
  output eif_pkg::item_t      q_item,
  output logic                q_valid,
  input  logic                q_pop
);

  // Scope of an IPv4 address.
  function automatic logic [2:0] v4_class(input logic [31:0] v);
    logic [7:0] a;
    logic [7:0] b;
    logic [2:0] c;
    a = v[31:24];
    b = v[23:16];
    if (a == 8'd127) c = eif_pkg::CLS_LOOPBACK;
    else if (a == 8'd169 && b == 8'd254) c = eif_pkg::CLS_LINKLOCAL;
    else if (a == 8'd10) c = eif_pkg::CLS_PRIVATE;
    else if (a == 8'd172 && b >= 8'd16 && b <= 8'd31) c = eif_pkg::CLS_PRIVATE;
    else if (a == 8'd192 && b == 8'd168) c = eif_pkg::CLS_PRIVATE;
    else if (a == 8'd100 && b >= 8'd64 && b <= 8'd127) c = eif_pkg::CLS_PRIVATE;
    else if (a == 8'd0) c = eif_pkg::CLS_UNSPECIFIED;
    else if (a >= 8'd224 && a <= 8'd239) c = eif_pkg::CLS_MULTICAST;
    else if (a >= 8'd240) c = eif_pkg::CLS_RESERVED;
    else c = eif_pkg::CLS_PUBLIC;
    return c;
  endfunction

  // Scope of an IPv6 address, unwrapping embedded IPv4 forms first.
  function automatic logic [2:0] v6_class(input logic [63:0] hi, input logic [63:0] lo);
    logic [7:0] b0;
    logic [7:0] b1;
    logic       hi_zero;
    logic [2:0] c;
    b0 = hi[63:56];
    b1 = hi[55:48];
    hi_zero = (hi == 64'd0);
    if (hi_zero && lo == 64'd0) c = eif_pkg::CLS_UNSPECIFIED;
    else if (hi_zero && lo == 64'd1) c = eif_pkg::CLS_LOOPBACK;
    else if (hi_zero && lo[63:32] == 32'h0000ffff) c = v4_class(lo[31:0]);
    else if (hi_zero && lo[63:32] == 32'd0) c = v4_class(lo[31:0]);
    else if (hi == 64'h0064ff9b00000000 && lo[63:32] == 32'd0) c = v4_class(lo[31:0]);
    else if (hi[63:48] == 16'h2002) c = v4_class(hi[47:16]);
    else if (b0 == 8'hfe && (b1 & 8'hc0) == 8'h80) c = eif_pkg::CLS_LINKLOCAL;
    else if ((b0 & 8'hfe) == 8'hfc) c = eif_pkg::CLS_PRIVATE;
    else if (b0 == 8'hff) c = eif_pkg::CLS_MULTICAST;
    else if (hi[63:32] == 32'h20010000) c = eif_pkg::CLS_RESERVED;
    else if (hi[63:32] == 32'h20010db8) c = eif_pkg::CLS_RESERVED;
    else if ((b0 & 8'he0) == 8'h20) c = eif_pkg::CLS_PUBLIC;
    else c = eif_pkg::CLS_RESERVED;
    return c;
  endfunction

  eif_pkg::item_t                  in_item;
  eif_pkg::item_t                  queue [eif_pkg::QUEUE_DEPTH];
  logic [eif_pkg::QPTR_W-1:0]      wr_ptr;
  logic [eif_pkg::QPTR_W-1:0]      rd_ptr;
  logic [eif_pkg::QCNT_W-1:0]      fill;
  logic                            push;
  logic                            pop;

  // Normalize the address and classify it.
  always_comb begin
    in_item.opcode  = s_tuser[1:0];
    in_item.is_ipv6 = s_tuser[2];
    if (s_tuser[2]) begin
      in_item.addr_hi  = s_tdata[63:0];
      in_item.addr_lo  = s_tdata[127:64];
      in_item.ip_class = v6_class(s_tdata[63:0], s_tdata[127:64]);
    end else begin
      in_item.addr_hi  = 64'd0;
      in_item.addr_lo  = {32'd0, s_tdata[95:64]};
      in_item.ip_class = v4_class(s_tdata[95:64]);
    end
  end

  assign s_tready = (fill != eif_pkg::QCNT_W'(eif_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == eif_pkg::QPTR_W'(eif_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == eif_pkg::QPTR_W'(eif_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### sv/eif_back.sv
// Back end: scans the allowlist, applies edits and issues the verdict.
module eif_back (
  input  logic                      clk,
  input  logic                      rst,
  input  eif_pkg::item_t            q_item,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic                      strict_allowlist,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_t;

  state_t                          state;
  eif_pkg::item_t                  cur;
  logic [eif_pkg::IDX_W-1:0]       scan_idx;
  logic                            issuing;
  logic                            cmp_valid;
  logic [eif_pkg::IDX_W-1:0]       cmp_idx;
  logic                            found;
  logic [eif_pkg::IDX_W-1:0]       slot;
  logic                            free_found;
  logic [eif_pkg::IDX_W-1:0]       free_slot;
  logic [eif_pkg::LIST_ENTRIES-1:0] entry_valid;
  logic [eif_pkg::CNT_W-1:0]       entry_count;
  logic [eif_pkg::ENTRY_W-1:0]     rd_entry;
  logic [eif_pkg::ENTRY_W-1:0]     wr_entry;
  logic                            hit;
  logic                            out_free;
  logic                            add_ok;
  logic                            remove_ok;
  logic                            check_ok;
  logic                            op_ok;
  logic                            ram_we;

  // Entry storage: family, high half, low half.
  eif_ram #(
    .WIDTH(eif_pkg::ENTRY_W),
    .DEPTH(eif_pkg::LIST_ENTRIES)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_slot),
    .wdata(wr_entry),
    .re   (issuing),
    .raddr(scan_idx),
    .rdata(rd_entry)
  );

  assign wr_entry = {cur.is_ipv6, cur.addr_hi, cur.addr_lo};
  assign hit = cmp_valid && entry_valid[cmp_idx] && (rd_entry == wr_entry);

  // Decisions made once the scan is complete.
  assign out_free  = !m_tvalid || m_tready;
  assign check_ok  = found || (!strict_allowlist && cur.ip_class == eif_pkg::CLS_PUBLIC);
  assign add_ok    = (cur.opcode == eif_pkg::OP_ADD) && !found && free_found &&
                     (entry_count < eif_pkg::CNT_W'(eif_pkg::LIST_ENTRIES));
  assign remove_ok = (cur.opcode == eif_pkg::OP_REMOVE) && found;
  assign ram_we    = (state == ST_EXEC) && out_free && add_ok;
  assign q_pop     = (state == ST_IDLE) && q_valid;

  // Outcome reported in op_ok for each opcode.
  always_comb begin
    case (cur.opcode)
      eif_pkg::OP_CHECK:  op_ok = check_ok;
      eif_pkg::OP_ADD:    op_ok = add_ok;
      eif_pkg::OP_REMOVE: op_ok = remove_ok;
      default:            op_ok = 1'b0;
    endcase
  end

  // Sequencer, list bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issuing     <= 1'b0;
      cmp_valid   <= 1'b0;
      entry_valid <= '0;
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // A taken result empties the output register unless a new one loads it.
      if (m_tvalid && m_tready && state != ST_EXEC) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur        <= q_item;
            scan_idx   <= '0;
            issuing    <= 1'b1;
            cmp_valid  <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // One RAM read issued and one entry compared per cycle.
          cmp_valid <= issuing;
          cmp_idx   <= scan_idx;
          if (issuing) begin
            if (scan_idx == eif_pkg::IDX_W'(eif_pkg::LIST_ENTRIES - 1)) begin
              issuing <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (hit && !found) begin
            found <= 1'b1;
            slot  <= cmp_idx;
          end
          if (cmp_valid && !entry_valid[cmp_idx] && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= cmp_idx;
          end
          if (cmp_valid && !issuing) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, op_ok, found, cur.ip_class,
                         (cur.opcode == eif_pkg::OP_CHECK) && check_ok};
            if (add_ok) begin
              entry_valid[free_slot] <= 1'b1;
              entry_count            <= entry_count + 1'b1;
            end
            if (remove_ok) begin
              entry_valid[slot] <= 1'b0;
              if (entry_count != '0) begin
                entry_count <= entry_count - 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/egress_ip_filter.sv
// Top level of the egress IP filter: configuration register, front end and back end.
//
// Each transaction on the slave side carries an opcode (check, add, remove) and an
// IPv4 or IPv6 address; each produces exactly one result transaction on the master
// side, in order. The front end classifies the address in the cycle it is accepted
// and places it in a two-entry queue, so it keeps taking transactions while the back
// end works. The back end walks the allowlist RAM one entry per cycle. Each transaction
// occupies it while it pops the queue, reads every entry, compares the last one read,
// then applies the edit and loads the output register once that register is free; no
// new transaction is popped before then. The sustained rate is set by that scan.
// Entries never written are masked by per-entry valid bits, so no clearing pass is
// needed after reset. strict_allowlist should only be written while the block is idle.
module egress_ip_filter (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,   // strict_allowlist
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,       // addr_hi [63:0], addr_lo [127:64]
  input  logic [2:0]   s_tuser,       // opcode [1:0], is_ipv6 [2]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata        // allowed [0], ip_class [3:1], listed [4],
                                      // op_ok [5], zero [7:6]
);

  logic                 strict_allowlist;
  eif_pkg::item_t       q_item;
  logic                 q_valid;
  logic                 q_pop;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strict_allowlist <= 1'b0;
    end else if (cfg_wr_en) begin
      strict_allowlist <= cfg_wr_data;
    end
  end

  // Classifier and request queue.
  eif_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // Allowlist engine.
  eif_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_item          (q_item),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .strict_allowlist(strict_allowlist),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

endmodule

### sim/tb.sv
// Testbench for egress_ip_filter: address classes, allowlist edits and strict mode.
`timescale 1ns / 100ps

module tb;

  // Opcode value that the block must treat as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int GAP_MAX     = 13;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 255;
  localparam int POOL_SIZE   = 24;
  localparam int SETTLE_CYC  = 40;

  // One result transaction, field by field.
  typedef struct packed {
    bit       allowed;
    bit [2:0] ip_class;
    bit       listed;
    bit       op_ok;
  } verdict_t;

  // One address as it travels on the slave side.
  typedef struct packed {
    bit        is_ipv6;
    bit [63:0] hi;
    bit [63:0] lo;
  } address_t;

  // Tracks the allowlist and the strict flag, and predicts the verdict for each
  // accepted request; results are checked in order against that prediction.
  class allowlist_tracker;
    bit [63:0]   ent_hi [eif_pkg::LIST_ENTRIES];
    bit [63:0]   ent_lo [eif_pkg::LIST_ENTRIES];
    bit          ent_fam [eif_pkg::LIST_ENTRIES];
    bit          ent_vld [eif_pkg::LIST_ENTRIES];
    int unsigned ent_count;
    bit          strict_mode;
    verdict_t    verdicts_due[$];
    int unsigned errors;

    function new();
      foreach (ent_vld[i]) ent_vld[i] = 1'b0;
      ent_count   = 0;
      strict_mode = 1'b0;
      errors      = 0;
    endfunction

    function bit [2:0] scope_v4(bit [31:0] v);
      bit [7:0] a;
      bit [7:0] b;
      a = v[31:24];
      b = v[23:16];
      if (a == 8'd127) return eif_pkg::CLS_LOOPBACK;
      if (a == 8'd169 && b == 8'd254) return eif_pkg::CLS_LINKLOCAL;
      if (a == 8'd10) return eif_pkg::CLS_PRIVATE;
      if (a == 8'd172 && b >= 8'd16 && b <= 8'd31) return eif_pkg::CLS_PRIVATE;
      if (a == 8'd192 && b == 8'd168) return eif_pkg::CLS_PRIVATE;
      if (a == 8'd100 && b >= 8'd64 && b <= 8'd127) return eif_pkg::CLS_PRIVATE;
      if (a == 8'd0) return eif_pkg::CLS_UNSPECIFIED;
      if (a >= 8'd224 && a <= 8'd239) return eif_pkg::CLS_MULTICAST;
      if (a >= 8'd240) return eif_pkg::CLS_RESERVED;
      return eif_pkg::CLS_PUBLIC;
    endfunction

    // Embedded IPv4 forms are unwrapped before the native IPv6 ranges.
    function bit [2:0] scope_v6(bit [63:0] hi, bit [63:0] lo);
      if (hi == 64'd0 && lo == 64'd0) return eif_pkg::CLS_UNSPECIFIED;
      if (hi == 64'd0 && lo == 64'd1) return eif_pkg::CLS_LOOPBACK;
      if (hi == 64'd0 && lo[63:32] == 32'h0000_ffff) return scope_v4(lo[31:0]);
      if (hi == 64'd0 && lo[63:32] == 32'd0) return scope_v4(lo[31:0]);
      if (hi == 64'h0064_ff9b_0000_0000 && lo[63:32] == 32'd0) return scope_v4(lo[31:0]);
      if (hi[63:48] == 16'h2002) return scope_v4(hi[47:16]);
      if (hi[63:56] == 8'hfe && hi[55:54] == 2'b10) return eif_pkg::CLS_LINKLOCAL;
      if (hi[63:57] == 7'b1111110) return eif_pkg::CLS_PRIVATE;
      if (hi[63:56] == 8'hff) return eif_pkg::CLS_MULTICAST;
      if (hi[63:32] == 32'h2001_0000) return eif_pkg::CLS_RESERVED;
      if (hi[63:32] == 32'h2001_0db8) return eif_pkg::CLS_RESERVED;
      if (hi[63:61] == 3'b001) return eif_pkg::CLS_PUBLIC;
      return eif_pkg::CLS_RESERVED;
    endfunction

    // Called once per accepted request transaction.
    function void note_request(bit [1:0] op, bit fam, bit [63:0] hi, bit [63:0] lo);
      verdict_t v;
      int       slot;
      v    = '0;
      slot = -1;
      if (!fam) begin
        hi         = 64'd0;
        lo         = {32'd0, lo[31:0]};
        v.ip_class = scope_v4(lo[31:0]);
      end else begin
        v.ip_class = scope_v6(hi, lo);
      end
      for (int i = 0; i < eif_pkg::LIST_ENTRIES; i++) begin
        if (slot < 0 && ent_vld[i] && ent_fam[i] == fam && ent_hi[i] == hi && ent_lo[i] == lo)
          slot = i;
      end
      v.listed = (slot >= 0);
      case (op)
        eif_pkg::OP_CHECK: begin
          v.allowed = v.listed || (!strict_mode && v.ip_class == eif_pkg::CLS_PUBLIC);
          v.op_ok   = v.allowed;
        end
        eif_pkg::OP_ADD: begin
          if (!v.listed && ent_count < eif_pkg::LIST_ENTRIES) begin
            for (int i = 0; i < eif_pkg::LIST_ENTRIES; i++) begin
              if (!v.op_ok && !ent_vld[i]) begin
                ent_vld[i] = 1'b1;
                ent_fam[i] = fam;
                ent_hi[i]  = hi;
                ent_lo[i]  = lo;
                ent_count++;
                v.op_ok = 1'b1;
              end
            end
          end
        end
        eif_pkg::OP_REMOVE: begin
          if (v.listed) begin
            ent_vld[slot] = 1'b0;
            ent_count--;
            v.op_ok = 1'b1;
          end
        end
        default: ;
      endcase
      verdicts_due.push_back(v);
    endfunction

    // Called once per accepted result transaction.
    function void check_verdict(logic [7:0] d);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("result %h arrived with no request outstanding", d);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (d[0] !== want.allowed) begin
        $error("allowed: expected %0d, got %0d", want.allowed, d[0]);
        errors++;
      end
      if (d[3:1] !== want.ip_class) begin
        $error("ip_class: expected %0d, got %0d", want.ip_class, d[3:1]);
        errors++;
      end
      if (d[4] !== want.listed) begin
        $error("listed: expected %0d, got %0d", want.listed, d[4]);
        errors++;
      end
      if (d[5] !== want.op_ok) begin
        $error("op_ok: expected %0d, got %0d", want.op_ok, d[5]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic         clk         = 1'b0;
  logic         rst         = 1'b1;
  logic         cfg_wr_en   = 1'b0;
  logic         cfg_wr_data = 1'b0;
  logic         s_tvalid    = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata     = '0;
  logic [2:0]   s_tuser     = '0;
  logic         m_tvalid;
  logic         m_tready    = 1'b0;
  logic [7:0]   m_tdata;

  bit               tx_burst = 1'b0;
  bit               rx_burst = 1'b0;
  int unsigned      rx_wait  = 0;
  allowlist_tracker tracker  = new();

  egress_ip_filter u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  // Clock.
  always #2 clk = ~clk;

  // Result side: check each transaction, then stall for a random number of cycles.
  always @(posedge clk) begin : result_side
    int unsigned n;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_tvalid && m_tready) begin
      tracker.check_verdict(m_tdata);
      if ($urandom_range(0, 47) == 0) rx_burst = ~rx_burst;
      n = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      rx_wait  <= n;
      m_tready <= (n == 0);
    end else if (rx_wait != 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic address_t addr_of(bit fam, bit [63:0] hi, bit [63:0] lo);
    address_t a;
    a.is_ipv6 = fam;
    a.hi      = hi;
    a.lo      = lo;
    return a;
  endfunction

  // IPv4 address biased toward the edges of the special ranges.
  function automatic bit [31:0] rand_v4();
    bit [7:0] a;
    bit [7:0] b;
    case ($urandom_range(0, 11))
      0:       a = 8'd0;
      1:       a = 8'd10;
      2:       a = 8'd100;
      3:       a = 8'd127;
      4:       a = 8'd169;
      5:       a = 8'd172;
      6:       a = 8'd192;
      7:       a = 8'($urandom_range(224, 239));
      8:       a = 8'($urandom_range(240, 255));
      default: a = 8'($urandom_range(0, 255));
    endcase
    case (a)
      8'd169:  b = $urandom_range(0, 1) ? 8'd254 : 8'($urandom_range(252, 255));
      8'd172:  b = 8'($urandom_range(14, 33));
      8'd100:  b = 8'($urandom_range(60, 130));
      8'd192:  b = $urandom_range(0, 1) ? 8'd168 : 8'($urandom_range(0, 255));
      default: b = 8'($urandom_range(0, 255));
    endcase
    return {a, b, 16'($urandom)};
  endfunction

  // Address of a random kind: IPv4, each IPv6 embedding, each IPv6 range, near misses.
  function automatic address_t rand_address();
    address_t  a;
    bit [31:0] v4;
    v4        = rand_v4();
    a.is_ipv6 = 1'b1;
    a.hi      = {$urandom, $urandom};
    a.lo      = {$urandom, $urandom};
    case ($urandom_range(0, 17))
      0, 1, 2, 3: begin
        a.is_ipv6 = 1'b0;
        a.hi      = 64'd0;
        a.lo      = {32'd0, v4};
      end
      4:  begin a.hi = 64'd0; a.lo = 64'd0; end
      5:  begin a.hi = 64'd0; a.lo = 64'd1; end
      6:  begin a.hi = 64'd0; a.lo = {32'h0000_ffff, v4}; end
      7:  begin a.hi = 64'd0; a.lo = {32'd0, v4}; end
      8:  begin a.hi = 64'h0064_ff9b_0000_0000; a.lo = {32'd0, v4}; end
      9:  a.hi = {16'h2002, v4, a.hi[15:0]};
      10: a.hi[63:54] = 10'b1111_1110_10;
      11: a.hi[63:57] = 7'b1111110;
      12: a.hi[63:56] = 8'hff;
      13: a.hi[63:32] = 32'h2001_0000;
      14: a.hi[63:32] = 32'h2001_0db8;
      15: a.hi[63:61] = 3'b001;
      16: a.hi = $urandom_range(0, 1) ? 64'd0 : 64'h0064_ff9b_0000_0000;
      default: ;
    endcase
    return a;
  endfunction

  // Present one request after a random gap and wait until it is taken.
  task automatic send_item(input logic [1:0] op, input address_t a);
    int unsigned gap;
    if ($urandom_range(0, 47) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {a.lo, a.hi};
    s_tuser  <= {a.is_ipv6, op};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(op, a.is_ipv6, a.hi, a.lo);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Write the strict flag; only called while the block is idle.
  task automatic write_strict(input bit v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.strict_mode = v;
  endtask

  // Stimulus.
  initial begin
    address_t    pool [POOL_SIZE];
    address_t    a;
    logic [1:0]  op;
    int unsigned add_w;
    int unsigned rem_w;
    int unsigned r;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Class boundaries for both families, IPv4 with junk in the ignored bits.
    send_item(eif_pkg::OP_CHECK, addr_of(1'b0, '1, {32'hffff_ffff, 32'h0000_0000}));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b0, 64'd0, 64'hffff_ffff));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b0, 64'd0, 64'h0808_0808));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b0, 64'd0, 64'hac1f_0001));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b0, 64'd0, 64'h6440_0001));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'd0, 64'd0));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, '1, '1));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'd0, 64'd1));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'd0, {32'h0000_ffff, 32'h0a01_0203}));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'd0, {32'h0, 32'h0808_0404}));
    send_item(eif_pkg::OP_CHECK,
              addr_of(1'b1, 64'h0064_ff9b_0000_0000, {32'h0, 32'h7f00_0001}));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'h2002_c0a8_0101_0000, 64'd1));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'hfe80_0000_0000_0000, 64'd1));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'hfd00_0000_0000_0000, 64'd5));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'h2001_0db8_0000_0000, 64'd1));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'h2001_0000_0000_0000, 64'd1));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'h2606_4700_0000_0000, 64'd1));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b1, 64'h4000_0000_0000_0000, 64'd0));

    // Add, duplicate add with different junk bits, listed check, remove, absent remove.
    send_item(eif_pkg::OP_ADD, addr_of(1'b0, 64'h1234, {32'hdead_beef, 32'h0a00_0001}));
    send_item(eif_pkg::OP_ADD, addr_of(1'b0, 64'd0, 64'h0a00_0001));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b0, '1, 64'h0a00_0001));
    send_item(eif_pkg::OP_REMOVE, addr_of(1'b0, 64'd0, 64'h0a00_0001));
    send_item(eif_pkg::OP_REMOVE, addr_of(1'b0, 64'd0, 64'h0a00_0001));
    send_item(OP_UNUSED, addr_of(1'b1, 64'h2606_4700_0000_0000, 64'd1));

    // Strict mode: a public address is denied until it is listed.
    drain();
    write_strict(1'b1);
    send_item(eif_pkg::OP_CHECK, addr_of(1'b0, 64'd0, 64'h0808_0808));
    send_item(eif_pkg::OP_ADD, addr_of(1'b0, 64'd0, 64'h0808_0808));
    send_item(eif_pkg::OP_CHECK, addr_of(1'b0, 64'd0, 64'h0808_0808));
    drain();

    // Address pool, larger than the table, with a few family twins of IPv4 entries.
    foreach (pool[i]) pool[i] = rand_address();
    for (int i = 0; i < 4; i++) begin
      pool[POOL_SIZE - 4 + i] = addr_of(~pool[i].is_ipv6, pool[i].hi, {32'd0, pool[i].lo[31:0]});
      pool[i].lo[63:32] = pool[i].is_ipv6 ? 32'd0 : pool[i].lo[63:32];
      pool[i].hi = 64'd0;
    end

    // Random phases: fill, drain and mixed edit loads, strict flag alternating.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_strict(phase[0]);
      case (phase)
        1: begin add_w = 60; rem_w = 5; end
        2: begin add_w = 5; rem_w = 50; end
        default: begin
          add_w = $urandom_range(10, 40);
          rem_w = $urandom_range(5, 30);
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < add_w) op = eif_pkg::OP_ADD;
        else if (r < add_w + rem_w) op = eif_pkg::OP_REMOVE;
        else if (r < 97) op = eif_pkg::OP_CHECK;
        else op = OP_UNUSED;
        if (op == eif_pkg::OP_ADD || op == eif_pkg::OP_REMOVE || $urandom_range(0, 9) < 6)
          a = pool[$urandom_range(0, POOL_SIZE - 1)];
        else
          a = rand_address();
        if (!a.is_ipv6) begin
          if ($urandom_range(0, 1)) a.hi = {$urandom, $urandom};
          if ($urandom_range(0, 1)) a.lo[63:32] = $urandom;
        end
        send_item(op, a);
      end
      drain();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### egress_ip_filter.f
sv/eif_pkg.sv
sv/eif_ram.sv
sv/eif_front.sv
sv/eif_back.sv
sv/egress_ip_filter.sv
sim/tb.sv
